// ===== src/tdei_pkg.sv =====
// Package for the text display escape interpreter.
// Holds character codes, parser phase codes, function codes, clear modes, register indexes and parser helpers.
// No dependencies.
package tdei_pkg;

  typedef logic [7:0] char_t;
  typedef logic [2:0] phase_t;
  typedef logic [1:0] func_t;

  // Cell value after reset and after any clear or pad
  localparam char_t EMPTY_CELL = 8'h2E;

  // Stream characters with a meaning to the parser
  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_N      = 8'h6E;
  localparam char_t CH_E      = 8'h65;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_H      = 8'h48;
  localparam char_t CH_J      = 8'h4A;

  // Parser phases
  localparam phase_t PH_IDLE   = 3'd0;
  localparam phase_t PH_BSLASH = 3'd1;
  localparam phase_t PH_ESC    = 3'd2;
  localparam phase_t PH_NUM1   = 3'd3;
  localparam phase_t PH_NUM2   = 3'd4;

  // Item functions
  localparam func_t FN_START = 2'd0;
  localparam func_t FN_CHAR  = 2'd1;
  localparam func_t FN_READ  = 2'd2;
  localparam func_t FN_NOP   = 2'd3;

  // Clear modes of the J sequence
  localparam char_t CLR_TO_END   = 8'd0;
  localparam char_t CLR_TO_START = 8'd1;
  localparam char_t CLR_ALL      = 8'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ROWS    = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_STRIDE  = 2'd2;

  localparam logic [7:0] NUM_MAX = 8'd255;

  function automatic logic is_digit(input char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input char_t c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Append one decimal digit, saturating at 255
  function automatic logic [7:0] add_digit(input logic [7:0] acc, input char_t c);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(c[3:0]);
    return (v > 12'(NUM_MAX)) ? NUM_MAX : v[7:0];
  endfunction

endpackage

// ===== src/tdei_if.sv =====
// Valid/ready channel interfaces for the input and result items.
// Depends on tdei_pkg for the field types.
interface tdei_in_if;
  logic                valid;
  logic                ready;
  tdei_pkg::func_t     func;
  tdei_pkg::char_t     char_code;
  logic [6:0]          cell_address;

  modport source (output valid, func, char_code, cell_address, input ready);
  modport sink   (input valid, func, char_code, cell_address, output ready);
endinterface

interface tdei_out_if;
  logic                valid;
  logic                ready;
  tdei_pkg::char_t     read_data;
  logic [6:0]          cursor_pos;

  modport source (output valid, read_data, cursor_pos, input ready);
  modport sink   (input valid, read_data, cursor_pos, output ready);
endinterface

// ===== src/tdei_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tdei_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/tdei_rem.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
// Shared by the wrap check and the newline pad. No dependencies.
module tdei_rem #(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int CNTW = $clog2(W + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]    acc;
  logic [W-1:0]    shf;
  logic [W-1:0]    dsr;
  logic [W:0]      shifted;

  assign shifted   = {acc, shf[W-1]};
  assign remainder = acc;

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        shf  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        if (shifted >= {1'b0, dsr}) begin
          acc <= W'(shifted - {1'b0, dsr});
        end else begin
          acc <= shifted[W-1:0];
        end
        shf <= {shf[W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/text_display_escape_interpreter.sv =====
// Character display store with cursor and escape sequence interpreter.
// An in-range read passes S_READ and a cursor move S_HOME before S_EMIT; start, nop and
// other escape steps go straight to S_EMIT; a plain char and a newline pad first wait on
// the remainder unit, and a clear goes one cell per cycle through the single RAM port.
// One item at a time; the next is taken once the previous result is registered.
// Reset: synchronous; a clearing pass fills the store with '.'.
module text_display_escape_interpreter #(
  parameter int CAPACITY = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tdei_in_if.sink     in_item,
  tdei_out_if.source  out_item
);
  import tdei_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 2);
  localparam int DW = (CW > 7) ? CW : 7;
  localparam int HW = DW + 4;
  localparam int XW = CW + 7;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_READ   = 4'd1;
  localparam logic [3:0] S_PMOD   = 4'd2;
  localparam logic [3:0] S_PADMOD = 4'd3;
  localparam logic [3:0] S_PAD    = 4'd4;
  localparam logic [3:0] S_CLR    = 4'd5;
  localparam logic [3:0] S_HOME   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  // Control and parser state
  logic [3:0]    state, state_next;
  logic [CW-1:0] cursor, cursor_next;
  phase_t        phase, phase_next;
  logic [7:0]    first_num, first_num_next;
  logic [7:0]    second_num, second_num_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] last, last_next;
  logic          sweep_emit, sweep_emit_next;
  logic [DW-1:0] pad_rem, pad_rem_next;
  char_t         res_data, res_data_next;
  logic          out_valid;
  char_t         out_data;
  logic [CW-1:0] out_cursor;

  // Configuration
  logic [2:0] rows_r;
  logic [6:0] cols_r;
  logic [6:0] stride_r;

  // Shared units
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  char_t         ram_wdata;
  char_t         ram_rdata;
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] div_rem;

  // Effective configuration
  logic [2:0]    rows_eff;
  logic [DW-1:0] cols_eff;
  logic [DW-1:0] stride_eff;

  // Helper values
  logic [DW:0]   wrap_sum;
  logic [DW:0]   pad_rem_inc;
  logic [CW:0]   cursor_inc;
  logic [2:0]    n_c;
  logic [6:0]    m_c;
  logic [HW-1:0] home_pos;
  logic          out_free;
  logic          do_plain;
  char_t         c;

  assign rows_eff   = (rows_r == 3'd0) ? 3'd1 : rows_r;
  assign cols_eff   = (cols_r == 7'd0) ? DW'(1) : DW'(cols_r);
  assign stride_eff = (stride_r == 7'd0) ? DW'(CAPACITY) : DW'(stride_r);

  assign c           = in_item.char_code;
  assign wrap_sum    = (DW + 1)'(cursor) + (DW + 1)'(stride_eff) - (DW + 1)'(cols_eff);
  assign pad_rem_inc = (DW + 1)'(pad_rem) + 1'b1;
  assign cursor_inc  = (CW + 1)'(cursor) + 1'b1;
  assign out_free    = !out_valid || out_item.ready;

  // Clamp the cursor position numbers of the H sequence
  always_comb begin
    if (first_num < 8'd1) begin
      n_c = 3'd1;
    end else if (first_num > 8'(rows_eff)) begin
      n_c = rows_eff;
    end else begin
      n_c = first_num[2:0];
    end
    if (second_num < 8'd1) begin
      m_c = 7'd1;
    end else if (second_num > 8'(cols_eff)) begin
      m_c = cols_eff[6:0];
    end else begin
      m_c = second_num[6:0];
    end
    home_pos = HW'((n_c - 3'd1) * stride_eff) + HW'(m_c) - HW'(1);
  end

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_r   <= 3'd4;
      cols_r   <= 7'd5;
      stride_r <= 7'd20;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ROWS:    rows_r   <= pwdata[2:0];
        REG_COLUMNS: cols_r   <= pwdata[6:0];
        REG_STRIDE:  stride_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:    prdata = 32'(rows_r);
      REG_COLUMNS: prdata = 32'(cols_r);
      REG_STRIDE:  prdata = 32'(stride_r);
      default:     prdata = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    phase_next      = phase;
    first_num_next  = first_num;
    second_num_next = second_num;
    ptr_next        = ptr;
    last_next       = last;
    sweep_emit_next = sweep_emit;
    pad_rem_next    = pad_rem;
    res_data_next   = res_data;
    ram_we          = 1'b0;
    ram_addr        = cursor[AW-1:0];
    ram_wdata       = EMPTY_CELL;
    div_start       = 1'b0;
    div_dividend    = DW'(cursor);
    do_plain        = 1'b0;

    case (state)
      S_IDLE: begin
        ram_addr = AW'(in_item.cell_address);
        if (in_item.valid) begin
          res_data_next = '0;
          state_next    = S_EMIT;
          case (in_item.func)
            FN_START: begin
              cursor_next = '0;
              phase_next  = PH_IDLE;
            end
            FN_READ: begin
              if (XW'(in_item.cell_address) < XW'(CAPACITY)) begin
                state_next = S_READ;
              end
            end
            FN_CHAR: begin
              case (phase)
                PH_BSLASH: begin
                  phase_next = PH_IDLE;
                  if (c == CH_N) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(cursor);
                    state_next   = S_PADMOD;
                  end else if (c == CH_E) begin
                    phase_next = PH_ESC;
                  end
                end
                PH_ESC: begin
                  if (c == CH_LBRACK) begin
                    first_num_next  = 8'd0;
                    second_num_next = 8'd1;
                    phase_next      = PH_NUM1;
                  end else begin
                    phase_next = PH_IDLE;
                    do_plain   = 1'b1;
                  end
                end
                PH_NUM1, PH_NUM2: begin
                  if (is_digit(c)) begin
                    if (phase == PH_NUM1) begin
                      first_num_next = add_digit(first_num, c);
                    end else begin
                      second_num_next = add_digit(second_num, c);
                    end
                  end else if (c == CH_SEMI && phase == PH_NUM1) begin
                    second_num_next = 8'd0;
                    phase_next      = PH_NUM2;
                  end else if (is_alpha(c)) begin
                    phase_next = PH_IDLE;
                    if (c == CH_H) begin
                      state_next = S_HOME;
                    end else if (c == CH_J) begin
                      sweep_emit_next = 1'b1;
                      case (first_num)
                        CLR_TO_END: begin
                          if (cursor < CW'(CAPACITY)) begin
                            ptr_next   = cursor[AW-1:0];
                            last_next  = AW'(CAPACITY - 1);
                            state_next = S_CLR;
                          end
                        end
                        CLR_TO_START: begin
                          ptr_next   = '0;
                          last_next  = (cursor < CW'(CAPACITY)) ? cursor[AW-1:0]
                                                                : AW'(CAPACITY - 1);
                          state_next = S_CLR;
                        end
                        CLR_ALL: begin
                          ptr_next   = '0;
                          last_next  = AW'(CAPACITY - 1);
                          state_next = S_CLR;
                        end
                        default: ;
                      endcase
                    end
                  end else begin
                    phase_next = PH_IDLE;
                    do_plain   = 1'b1;
                  end
                end
                default: begin
                  phase_next = PH_IDLE;
                  do_plain   = 1'b1;
                end
              endcase

              // Store a plain character and start the wrap check; a NUL, a backslash or a full store is not written
              if (do_plain) begin
                if (c == CH_NUL) begin
                  state_next = S_EMIT;
                end else if (c == CH_BSLASH) begin
                  phase_next = PH_BSLASH;
                end else if (cursor >= CW'(CAPACITY)) begin
                  cursor_next = CW'(CAPACITY);
                end else begin
                  ram_we       = 1'b1;
                  ram_addr     = cursor[AW-1:0];
                  ram_wdata    = c;
                  cursor_next  = cursor_inc[CW-1:0];
                  div_start    = 1'b1;
                  div_dividend = DW'(cursor_inc);
                  state_next   = S_PMOD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        res_data_next = ram_rdata;
        state_next    = S_EMIT;
      end

      // Jump to the next row start when the column count is reached
      S_PMOD: begin
        if (div_done) begin
          if (div_rem == cols_eff) begin
            if (wrap_sum > (DW + 1)'(CAPACITY)) begin
              cursor_next = CW'(CAPACITY);
            end else begin
              cursor_next = CW'(wrap_sum);
            end
          end
          state_next = S_EMIT;
        end
      end

      S_PADMOD: begin
        if (div_done) begin
          pad_rem_next = div_rem;
          state_next   = S_PAD;
        end
      end

      // Pad one cell per cycle up to the next row start or the end of the store
      S_PAD: begin
        ram_addr = cursor[AW-1:0];
        ram_we   = cursor < CW'(CAPACITY);
        if (pad_rem_inc == (DW + 1)'(stride_eff)) begin
          pad_rem_next = '0;
        end else begin
          pad_rem_next = pad_rem_inc[DW-1:0];
        end
        if (cursor_inc >= (CW + 1)'(CAPACITY)) begin
          cursor_next = CW'(CAPACITY);
          state_next  = S_EMIT;
        end else begin
          cursor_next = cursor_inc[CW-1:0];
          if (pad_rem_inc == (DW + 1)'(stride_eff)) begin
            state_next = S_EMIT;
          end
        end
      end

      // Clear one cell per cycle over the sweep range
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = ptr;
        if (ptr == last) begin
          state_next = sweep_emit ? S_EMIT : S_IDLE;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end

      S_HOME: begin
        if (home_pos > HW'(CAPACITY)) begin
          cursor_next = CW'(CAPACITY);
        end else begin
          cursor_next = CW'(home_pos);
        end
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      cursor     <= '0;
      phase      <= PH_IDLE;
      first_num  <= '0;
      second_num <= '0;
      ptr        <= '0;
      last       <= AW'(CAPACITY - 1);
      sweep_emit <= 1'b0;
    end else begin
      state      <= state_next;
      cursor     <= cursor_next;
      phase      <= phase_next;
      first_num  <= first_num_next;
      second_num <= second_num_next;
      ptr        <= ptr_next;
      last       <= last_next;
      sweep_emit <= sweep_emit_next;
    end
  end

  always_ff @(posedge clk) begin
    pad_rem  <= pad_rem_next;
    res_data <= res_data_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data   <= res_data;
      out_cursor <= cursor;
    end
  end

  assign in_item.ready       = (state == S_IDLE);
  assign out_item.valid      = out_valid;
  assign out_item.read_data  = out_data;
  assign out_item.cursor_pos = 7'(out_cursor);

  tdei_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tdei_rem #(
    .W (DW)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (stride_eff),
    .done      (div_done),
    .remainder (div_rem)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the text display escape interpreter.
// Drives write-stream items and register writes, predicts every status item.
// Depends on tdei_pkg, the tdei_in_if/tdei_out_if interfaces and the RTL top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdei_pkg::*;

  localparam int CAP         = 80;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SWEEP_ITEMS = 120;
  localparam int SPRINT_ITEMS = 170;

  typedef struct packed {
    char_t      read_data;
    logic [6:0] cursor_pos;
  } disp_status_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tdei_in_if  in_if();
  tdei_out_if out_if();

  text_display_escape_interpreter #(.CAPACITY(CAP)) DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (in_if),
    .out_item (out_if)
  );

  // Shadow copy of the display store, cursor, parser and registers
  char_t       shadow_cells [CAP];
  int unsigned shadow_cursor;
  phase_t      shadow_phase;
  int unsigned shadow_n;
  int unsigned shadow_m;
  logic [2:0]  cfg_rows;
  logic [6:0]  cfg_cols;
  logic [6:0]  cfg_stride;

  disp_status_t awaited_status [$];
  int unsigned  items_sent;
  int unsigned  err_count;
  int unsigned  cycle_count;
  int unsigned  gap_pct;
  int unsigned  stall_pct;

  // Free-running clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Display predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_rows();
    return (cfg_rows == 3'd0) ? 1 : int'(cfg_rows);
  endfunction

  function automatic int unsigned eff_cols();
    return (cfg_cols == 7'd0) ? 1 : int'(cfg_cols);
  endfunction

  function automatic int unsigned eff_stride();
    return (cfg_stride == 7'd0) ? CAP : int'(cfg_stride);
  endfunction

  function automatic bit is_decimal(char_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic bit is_letter(char_t c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic int unsigned push_digit(int unsigned acc, char_t c);
    int unsigned v;
    v = acc * 10 + (c & 8'h0F);
    return (v > 255) ? 255 : v;
  endfunction

  // Store one plain byte at the cursor and advance, wrapping at the column count
  function automatic void store_plain(char_t c);
    int unsigned stride;
    int unsigned cols;
    stride = eff_stride();
    cols   = eff_cols();
    if (c == CH_NUL) return;
    if (c == CH_BSLASH) begin
      shadow_phase = PH_BSLASH;
      return;
    end
    if (shadow_cursor >= CAP) begin
      shadow_cursor = CAP;
      return;
    end
    shadow_cells[shadow_cursor] = c;
    shadow_cursor++;
    if (shadow_cursor % stride == cols) shadow_cursor += stride - cols;
    if (shadow_cursor > CAP) shadow_cursor = CAP;
  endfunction

  // Fill the rest of the row with empty cells
  function automatic void pad_row();
    int unsigned stride;
    stride = eff_stride();
    do begin
      if (shadow_cursor < CAP) shadow_cells[shadow_cursor] = EMPTY_CELL;
      shadow_cursor++;
    end while ((shadow_cursor % stride != 0) && (shadow_cursor < CAP));
    if (shadow_cursor > CAP) shadow_cursor = CAP;
  endfunction

  // Execute a finished escape sequence: clear or cursor move
  function automatic void apply_sequence(char_t letter, int unsigned n, int unsigned m);
    int unsigned i;
    int unsigned r;
    int unsigned cl;
    if (letter == CH_J) begin
      if (n == CLR_TO_END) begin
        for (i = shadow_cursor; i < CAP; i++) shadow_cells[i] = EMPTY_CELL;
      end else if (n == CLR_TO_START) begin
        for (i = 0; (i <= shadow_cursor) && (i < CAP); i++) shadow_cells[i] = EMPTY_CELL;
      end else if (n == CLR_ALL) begin
        for (i = 0; i < CAP; i++) shadow_cells[i] = EMPTY_CELL;
      end
    end else if (letter == CH_H) begin
      r  = eff_rows();
      cl = eff_cols();
      if (n < 1) n = 1;
      if (n > r) n = r;
      if (m < 1) m = 1;
      if (m > cl) m = cl;
      shadow_cursor = (n - 1) * eff_stride() + (m - 1);
      if (shadow_cursor > CAP) shadow_cursor = CAP;
    end
  endfunction

  // Advance the escape parser by one stream byte
  function automatic void feed_char(char_t c);
    case (shadow_phase)
      PH_BSLASH: begin
        shadow_phase = PH_IDLE;
        if (c == CH_N) pad_row();
        else if (c == CH_E) shadow_phase = PH_ESC;
      end
      PH_ESC: begin
        if (c == CH_LBRACK) begin
          shadow_n     = 0;
          shadow_m     = 1;
          shadow_phase = PH_NUM1;
        end else begin
          shadow_phase = PH_IDLE;
          store_plain(c);
        end
      end
      PH_NUM1, PH_NUM2: begin
        if (is_decimal(c)) begin
          if (shadow_phase == PH_NUM1) shadow_n = push_digit(shadow_n, c);
          else shadow_m = push_digit(shadow_m, c);
        end else if ((c == CH_SEMI) && (shadow_phase == PH_NUM1)) begin
          shadow_m     = 0;
          shadow_phase = PH_NUM2;
        end else if (is_letter(c)) begin
          shadow_phase = PH_IDLE;
          apply_sequence(c, shadow_n, shadow_m);
        end else begin
          shadow_phase = PH_IDLE;
          store_plain(c);
        end
      end
      default: begin
        shadow_phase = PH_IDLE;
        store_plain(c);
      end
    endcase
  endfunction

  // Predict the status item caused by one accepted input item
  function automatic disp_status_t display_step(func_t f, char_t c, logic [6:0] a);
    disp_status_t r;
    r.read_data = '0;
    case (f)
      FN_START: begin
        shadow_cursor = 0;
        shadow_phase  = PH_IDLE;
      end
      FN_CHAR: feed_char(c);
      FN_READ: begin
        if (a < CAP) r.read_data = shadow_cells[a];
      end
      default: ;
    endcase
    r.cursor_pos = shadow_cursor[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sink side and checking
  // ---------------------------------------------------------------------------
  // Stall the result channel at random
  always @(posedge clk) begin
    out_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Compare each accepted status item with the oldest prediction
  always @(posedge clk) begin : check_status
    disp_status_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (awaited_status.size() == 0) begin
        $display("%0t: unexpected item: read_data %h cursor_pos %0d", $time,
                 out_if.read_data, out_if.cursor_pos);
        err_count++;
      end else begin
        want = awaited_status.pop_front();
        if (out_if.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch: expected %h actual %h", $time,
                   want.read_data, out_if.read_data);
          err_count++;
        end
        if (out_if.cursor_pos !== want.cursor_pos) begin
          $display("%0t: cursor_pos mismatch: expected %0d actual %0d", $time,
                   want.cursor_pos, out_if.cursor_pos);
          err_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_display_escape_interpreter: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  // Present one item, with random idle cycles ahead of it, and hold until taken
  task automatic send_item(func_t f, char_t c, logic [6:0] a);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= f;
    in_if.char_code    <= c;
    in_if.cell_address <= a;
    do @(posedge clk); while (!in_if.ready);
    awaited_status.push_back(display_step(f, c, a));
    if (f != FN_NOP) items_sent++;
  endtask

  task automatic send_char(char_t c);
    send_item(FN_CHAR, c, 7'($urandom_range(127)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(char_t'(s[i]));
  endtask

  task automatic send_number(int unsigned v);
    int unsigned d [$];
    do begin
      d.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    foreach (d[i]) send_char(char_t'(8'h30 + d[i]));
  endtask

  // Backslash, 'e', '[', optional n, optional ';' and m, final letter
  task automatic send_sequence(char_t letter, int unsigned n, int unsigned m,
                               bit has_n, bit has_semi, bit has_m);
    send_char(CH_BSLASH);
    send_char(CH_E);
    send_char(CH_LBRACK);
    if (has_n) send_number(n);
    if (has_semi) begin
      send_char(CH_SEMI);
      if (has_m) send_number(m);
    end
    send_char(letter);
  endtask

  // Drop valid and hold until every predicted item has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROWS:    cfg_rows   = value[2:0];
      REG_COLUMNS: cfg_cols   = value[6:0];
      REG_STRIDE:  cfg_stride = value[6:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned r, int unsigned c, int unsigned s);
    wait_drained();
    write_register(REG_ROWS, r);
    write_register(REG_COLUMNS, c);
    write_register(REG_STRIDE, s);
  endtask

  function automatic char_t text_byte();
    char_t c;
    if ($urandom_range(9) == 0) return char_t'($urandom_range(255));
    c = char_t'($urandom_range(8'h7E, 8'h20));
    if (c == CH_BSLASH) c = 8'h5D;
    return c;
  endfunction

  function automatic int unsigned seq_number();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 7) return $urandom_range(9);
    if (pick < 9) return $urandom_range(99);
    return $urandom_range(999);
  endfunction

  function automatic char_t any_letter();
    return $urandom_range(1) ? char_t'($urandom_range(8'h5A, 8'h41))
                             : char_t'($urandom_range(8'h7A, 8'h61));
  endfunction

  // One random chunk: mostly well-formed text and sequences, some noise, reads, starts and nops
  task automatic send_random_chunk();
    int unsigned kind;
    int unsigned len;
    int          near;
    kind = $urandom_range(99);
    if (kind < 30) begin
      len = $urandom_range(12, 1);
      repeat (len) send_char(text_byte());
    end else if (kind < 42) begin
      send_text("\\n");
    end else if (kind < 62) begin
      send_sequence(CH_H, seq_number(), seq_number(), $urandom_range(99) < 85,
                    $urandom_range(99) < 80, $urandom_range(99) < 85);
    end else if (kind < 72) begin
      send_sequence(CH_J, $urandom_range(3), seq_number(), $urandom_range(99) < 85,
                    $urandom_range(99) < 10, 1'b1);
    end else if (kind < 80) begin
      case ($urandom_range(4))
        0: begin
          send_char(CH_BSLASH);
          send_char(char_t'($urandom_range(255)));
        end
        1: begin
          send_char(CH_BSLASH);
          send_char(CH_E);
          send_char(char_t'($urandom_range(255)));
        end
        2: begin
          send_text("\\e[");
          if ($urandom_range(1)) send_number(seq_number());
          send_char(char_t'($urandom_range(255)));
        end
        3: send_sequence(any_letter(), seq_number(), seq_number(), 1'b1,
                         $urandom_range(1), 1'b1);
        default: begin
          send_text("\\e[");
          send_number(seq_number());
          send_char(CH_SEMI);
          send_number(seq_number());
          send_char(CH_SEMI);
        end
      endcase
    end else if (kind < 92) begin
      len = $urandom_range(4, 1);
      repeat (len) begin
        if ($urandom_range(1)) begin
          near = int'(shadow_cursor) + int'($urandom_range(6)) - 3;
          send_item(FN_READ, char_t'($urandom_range(255)), 7'(near));
        end else begin
          send_item(FN_READ, char_t'($urandom_range(255)),
                    7'($urandom_range(9) == 0 ? $urandom_range(127) : $urandom_range(79)));
        end
      end
    end else if (kind < 96) begin
      send_item(FN_START, char_t'($urandom_range(255)), 7'($urandom_range(127)));
    end else if (kind < 98) begin
      send_item(FN_NOP, char_t'($urandom_range(255)), 7'($urandom_range(127)));
    end else begin
      send_item(func_t'($urandom_range(3)), char_t'($urandom_range(255)),
                7'($urandom_range(127)));
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < count) send_random_chunk();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset contents, field extremes and each escape form at reset settings
  task automatic test_special_cases();
    send_item(FN_READ, 8'h00, 7'd0);
    send_item(FN_READ, 8'hFF, 7'd127);
    send_text("A");
    send_char(CH_NUL);
    send_char(8'hFF);
    send_text("\\n");
    send_text("\\q");
    send_sequence(CH_H, 2, 9, 1'b1, 1'b1, 1'b1);
    send_text("\\eZ");
    send_sequence(CH_J, CLR_TO_START, 0, 1'b1, 1'b0, 1'b0);
    send_item(FN_NOP, 8'h00, 7'd0);
    send_item(FN_START, 8'hFF, 7'd127);
  endtask

  // Random stream over a range of register settings, extremes and odd values
  task automatic test_settings_sweep();
    int unsigned rows_tab [9]   = '{4, 1, 4, 2, 0, 7, 4, 2, 1};
    int unsigned cols_tab [9]   = '{5, 1, 80, 80, 0, 127, 20, 19, 40};
    int unsigned stride_tab [9] = '{20, 20, 80, 20, 0, 127, 20, 80, 40};
    int unsigned legal_rows [3] = '{1, 2, 4};
    for (int p = 0; p < 9; p++) begin
      apply_settings(rows_tab[p], cols_tab[p], stride_tab[p]);
      run_random(SWEEP_ITEMS);
    end
    apply_settings(legal_rows[$urandom_range(2)], $urandom_range(80, 1),
                   $urandom_range(80, 20));
    run_random(SWEEP_ITEMS);
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    apply_settings(2, 19, 20);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(SPRINT_ITEMS);
    gap_pct   = 20;
    stall_pct = 20;
  endtask

  // Hold the sender until the block has drained, every few dozen items
  task automatic test_drained_pauses();
    apply_settings(4, 5, 20);
    repeat (5) begin
      run_random(SPRINT_ITEMS / 5);
      wait_drained();
    end
  endtask

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_if.valid        = 1'b0;
    in_if.func         = FN_NOP;
    in_if.char_code    = '0;
    in_if.cell_address = '0;
    items_sent    = 0;
    err_count     = 0;
    cycle_count   = 0;
    gap_pct       = 20;
    stall_pct     = 20;
    foreach (shadow_cells[i]) shadow_cells[i] = EMPTY_CELL;
    shadow_cursor = 0;
    shadow_phase  = PH_IDLE;
    shadow_n      = 0;
    shadow_m      = 0;
    cfg_rows      = 3'd4;
    cfg_cols      = 7'd5;
    cfg_stride    = 7'd20;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_settings_sweep();
    test_back_to_back();
    test_drained_pauses();

    wait_drained();
    repeat (CAP + 16) @(posedge clk);
    if (err_count == 0) begin
      $display("** text_display_escape_interpreter: PASSED **");
    end else begin
      $display("** text_display_escape_interpreter: FAILED **");
    end
    $finish;
  end

endmodule
